@@ rtl/core/version_tag_parse_compare_macros.svh @@
// ----------------------------------------------------------------------------
// Version tag parse and compare: assertion macros
// Concurrent check helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VERSION_TAG_PARSE_COMPARE_MACROS_SVH
`define VERSION_TAG_PARSE_COMPARE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define VTPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vtpc check failed");
// Next-cycle implication, disabled during reset.
`define VTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vtpc check failed");
`else
`define VTPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/vtpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Version tag parse and compare: package
// Shared types, character codes and the saturating digit accumulate.
// ----------------------------------------------------------------------------
package vtpc_pkg;

  localparam int unsigned NumW = 20;
  localparam logic [NumW-1:0] SatLimit = 20'd1000000;
  localparam int unsigned MidDepth = 2;

  localparam logic [7:0] ChLowerV = 8'h76;
  localparam logic [7:0] ChUpperV = 8'h56;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  localparam logic signed [1:0] OrdOlder = -2'sd1;
  localparam logic signed [1:0] OrdSame  = 2'sd0;
  localparam logic signed [1:0] OrdNewer = 2'sd1;

  typedef enum logic [3:0] {
    PH_LEAD    = 4'd0,
    PH_AFTER_V = 4'd1,
    PH_MAJOR   = 4'd2,
    PH_DOT1    = 4'd3,
    PH_MINOR   = 4'd4,
    PH_DOT2    = 4'd5,
    PH_PATCH   = 4'd6,
    PH_TRAIL   = 4'd7,
    PH_MARK    = 4'd8,
    PH_SUFFIX  = 4'd9,
    PH_BAD     = 4'd10
  } phase_t;

  // One finished string, as handed from the parser to the comparer.
  typedef struct packed {
    logic [NumW-1:0] major;
    logic [NumW-1:0] minor;
    logic [NumW-1:0] patch;
    logic            pre;
    logic            ok;
    logic            second;
  } rec_t;

  function automatic logic [NumW-1:0] sat_digit(input logic [NumW-1:0] acc,
                                                input logic [7:0] ch);
    logic [NumW+3:0] wide;
    logic [7:0]      dig;
    dig  = ch - ChZero;
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{(NumW - 4){1'b0}}, dig};
    if (wide > {4'b0, SatLimit}) begin
      return SatLimit;
    end
    return wide[NumW-1:0];
  endfunction

endpackage

@@ rtl/core/vtpc_front.sv @@
// ----------------------------------------------------------------------------
// Version tag parse and compare: front parser
// Walks one character per accepted word and emits a record at string end.
// ----------------------------------------------------------------------------
module vtpc_front
  import vtpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] char_code,
  input  logic       no_char,
  input  logic       end_of_string,
  input  logic       second_string,
  output logic       rec_push,
  output rec_t       rec
);

  phase_t          phase_r, phase_nxt;
  logic [NumW-1:0] major_r, major_nxt;
  logic [NumW-1:0] minor_r, minor_nxt;
  logic [NumW-1:0] patch_r, patch_nxt;
  logic            pre_r, pre_nxt;
  logic            is_ws, is_dig, is_mark;
  logic [NumW-1:0] acc_in, acc_out;
  logic            ok;

  always_comb begin
    is_ws   = (char_code == ChSpace) || (char_code inside {[ChTab:ChCr]});
    is_dig  = char_code inside {[ChZero:ChNine]};
    is_mark = (char_code == ChDash) || (char_code == ChPlus);
  end

  // Only one number grows per character, so one accumulate unit is shared.
  always_comb begin
    case (phase_r)
      PH_DOT1, PH_MINOR: acc_in = minor_r;
      PH_DOT2, PH_PATCH: acc_in = patch_r;
      default:           acc_in = major_r;
    endcase
    acc_out = sat_digit(acc_in, char_code);
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    patch_nxt = patch_r;
    pre_nxt   = pre_r;
    if (!no_char) begin
      case (phase_r)
        PH_LEAD: begin
          if (is_ws) begin
            phase_nxt = PH_LEAD;
          end else if ((char_code == ChLowerV) || (char_code == ChUpperV)) begin
            phase_nxt = PH_AFTER_V;
          end else if (is_dig) begin
            major_nxt = acc_out;
            phase_nxt = PH_MAJOR;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_AFTER_V: begin
          if (is_dig) begin
            major_nxt = acc_out;
            phase_nxt = PH_MAJOR;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_DOT1: begin
          if (is_dig) begin
            minor_nxt = acc_out;
            phase_nxt = PH_MINOR;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_DOT2: begin
          if (is_dig) begin
            patch_nxt = acc_out;
            phase_nxt = PH_PATCH;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_MAJOR, PH_MINOR, PH_PATCH, PH_TRAIL: begin
          if (is_dig && (phase_r != PH_TRAIL)) begin
            case (phase_r)
              PH_MAJOR: major_nxt = acc_out;
              PH_MINOR: minor_nxt = acc_out;
              default:  patch_nxt = acc_out;
            endcase
          end else if ((char_code == ChDot) && (phase_r == PH_MAJOR)) begin
            phase_nxt = PH_DOT1;
          end else if ((char_code == ChDot) && (phase_r == PH_MINOR)) begin
            phase_nxt = PH_DOT2;
          end else if (is_ws) begin
            phase_nxt = PH_TRAIL;
          end else if (is_mark) begin
            pre_nxt   = (char_code == ChDash);
            phase_nxt = PH_MARK;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_MARK, PH_SUFFIX: phase_nxt = PH_SUFFIX;
        default:            phase_nxt = PH_BAD;
      endcase
    end
  end

  // Outputs: the record seen if this word ends the string.
  always_comb begin
    ok = phase_nxt inside {PH_MAJOR, PH_MINOR, PH_PATCH, PH_TRAIL, PH_SUFFIX};
    rec_push   = take && end_of_string;
    rec.ok     = ok;
    rec.second = second_string;
    rec.major  = ok ? major_nxt : '0;
    rec.minor  = ok ? minor_nxt : '0;
    rec.patch  = ok ? patch_nxt : '0;
    rec.pre    = ok && pre_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      major_r <= '0;
      minor_r <= '0;
      patch_r <= '0;
      pre_r   <= 1'b0;
    end else if (take) begin
      if (end_of_string) begin
        phase_r <= PH_LEAD;
        major_r <= '0;
        minor_r <= '0;
        patch_r <= '0;
        pre_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        major_r <= major_nxt;
        minor_r <= minor_nxt;
        patch_r <= patch_nxt;
        pre_r   <= pre_nxt;
      end
    end
  end

endmodule

@@ rtl/core/vtpc_fifo.sv @@
// ----------------------------------------------------------------------------
// Version tag parse and compare: record queue
// Short first-in first-out buffer between the parser and the comparer.
// ----------------------------------------------------------------------------
module vtpc_fifo
  import vtpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  rec_t wr_data,
  input  logic rd_en,
  output rec_t rd_data,
  output logic q_full,
  output logic q_empty
);

  localparam int unsigned PtrW = (MidDepth > 1) ? $clog2(MidDepth) : 1;
  localparam int unsigned CntW = $clog2(MidDepth + 1);

  rec_t            mem_r [MidDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(MidDepth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign q_full  = (count_r == CntW'(MidDepth));
  assign q_empty = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CntW'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/core/vtpc_back.sv @@
// ----------------------------------------------------------------------------
// Version tag parse and compare: back comparer
// Holds the last first string, orders second strings and registers results.
// ----------------------------------------------------------------------------
module vtpc_back
  import vtpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  rec_t                   q_data,
  output logic                   q_pop,
  input  logic                   res_pop,
  output logic                   res_vld,
  output rec_t                   res,
  output logic signed [1:0]      res_order
);

  rec_t              held_r;
  logic              out_vld_r;
  rec_t              out_r;
  logic signed [1:0] ord_r, ord_nxt;
  logic [3*NumW-1:0] num_a, num_b;

  assign q_pop     = !q_empty && (!out_vld_r || res_pop);
  assign res_vld   = out_vld_r;
  assign res       = out_r;
  assign res_order = ord_r;

  always_comb begin
    num_a   = {held_r.major, held_r.minor, held_r.patch};
    num_b   = {q_data.major, q_data.minor, q_data.patch};
    ord_nxt = OrdSame;
    if (q_data.second && q_data.ok && held_r.ok) begin
      if (num_a < num_b) begin
        ord_nxt = OrdOlder;
      end else if (num_a > num_b) begin
        ord_nxt = OrdNewer;
      end else if (held_r.pre != q_data.pre) begin
        // A release ranks above its own pre-release.
        ord_nxt = held_r.pre ? OrdOlder : OrdNewer;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= q_data;
      ord_r <= ord_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      held_r    <= '0;
    end else begin
      if (q_pop) begin
        out_vld_r <= 1'b1;
      end else if (res_pop) begin
        out_vld_r <= 1'b0;
      end
      if (q_pop && !q_data.second) begin
        held_r <= q_data;
      end
    end
  end

endmodule

@@ rtl/core/version_tag_parse_compare.sv @@
// ----------------------------------------------------------------------------
// Version tag parse and compare: top level
// Streams two version strings and reports parsed fields and their order.
// ----------------------------------------------------------------------------
// Throughput: the parser takes one character word per cycle while full is low.
// A string's record enters the record queue when its ending word is taken, and
// its result shows once the record moves from the queue into the output register.
// full rises only when the two-entry record queue fills behind a stalled output.
// Reset (synchronous, rst_n low) clears the parser, queue, held string and output.
`include "version_tag_parse_compare_macros.svh"

module version_tag_parse_compare
  import vtpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_char_code,
  input  logic                   in_no_char,
  input  logic                   in_end_of_string,
  input  logic                   in_second_string,
  input  logic                   push,
  output logic                   full,
  output logic [19:0]            out_major_value,
  output logic [19:0]            out_minor_value,
  output logic [19:0]            out_patch_value,
  output logic                   out_is_prerelease,
  output logic                   out_parsed_ok,
  output logic                   out_result_for_second,
  output logic signed [1:0]      out_order,
  output logic                   empty,
  input  logic                   pop
);

  logic take;
  logic rec_push;
  rec_t rec_in, rec_head, res;
  logic q_full, q_empty, q_pop;
  logic res_vld;

  assign take = push && !q_full;
  assign full = q_full;

  vtpc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .char_code     (in_char_code),
    .no_char       (in_no_char),
    .end_of_string (in_end_of_string),
    .second_string (in_second_string),
    .rec_push      (rec_push),
    .rec           (rec_in)
  );

  vtpc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .rd_en   (q_pop),
    .rd_data (rec_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  vtpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (rec_head),
    .q_pop     (q_pop),
    .res_pop   (pop),
    .res_vld   (res_vld),
    .res       (res),
    .res_order (out_order)
  );

  assign empty                 = !res_vld;
  assign out_major_value       = res.major;
  assign out_minor_value       = res.minor;
  assign out_patch_value       = res.patch;
  assign out_is_prerelease     = res.pre;
  assign out_parsed_ok         = res.ok;
  assign out_result_for_second = res.second;

  // A nonzero order only comes with a valid second string.
  `VTPC_ASSERT_IMPL(a_order_needs_second, clk, rst_n,
                    !empty && (out_order != OrdSame),
                    out_result_for_second && out_parsed_ok)
  // An invalid string reports all-zero fields.
  `VTPC_ASSERT_IMPL(a_bad_fields_zero, clk, rst_n, !empty && !out_parsed_ok,
                    (out_major_value == '0) && (out_minor_value == '0) &&
                    (out_patch_value == '0) && !out_is_prerelease)
  // Taking the last result with nothing queued leaves the output empty.
  `VTPC_ASSERT_NEXT(a_drain_empty, clk, rst_n, !empty && pop && q_empty, empty)

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Version tag parse and compare: testbench
// Streams version strings into the block one character word at a time. A
// model of the parser and comparer in this file predicts each report, and
// every report popped from the block is checked against the oldest
// prediction. The run starts with directed corner strings, then moves to
// random well-formed, broken and noisy strings under random push and pop
// gaps.
// ----------------------------------------------------------------------------
module tb;
  import vtpc_pkg::*;

  typedef struct {
    logic [19:0]       major;
    logic [19:0]       minor;
    logic [19:0]       patch;
    logic              pre;
    logic              ok;
    logic              second;
    logic signed [1:0] order;
  } version_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [7:0]        in_char_code = 8'h00;
  logic              in_no_char = 1'b0;
  logic              in_end_of_string = 1'b0;
  logic              in_second_string = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [19:0]       out_major_value;
  logic [19:0]       out_minor_value;
  logic [19:0]       out_patch_value;
  logic              out_is_prerelease;
  logic              out_parsed_ok;
  logic              out_result_for_second;
  logic signed [1:0] out_order;
  logic              empty;
  logic              pop = 1'b0;

  version_tag_parse_compare DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_char_code          (in_char_code),
    .in_no_char            (in_no_char),
    .in_end_of_string      (in_end_of_string),
    .in_second_string      (in_second_string),
    .push                  (push),
    .full                  (full),
    .out_major_value       (out_major_value),
    .out_minor_value       (out_minor_value),
    .out_patch_value       (out_patch_value),
    .out_is_prerelease     (out_is_prerelease),
    .out_parsed_ok         (out_parsed_ok),
    .out_result_for_second (out_result_for_second),
    .out_order             (out_order),
    .empty                 (empty),
    .pop                   (pop)
  );

  always #4 clk = ~clk;

  // Parser and comparer model state.
  phase_t      scan_phase = PH_LEAD;
  logic [19:0] acc_major = '0;
  logic [19:0] acc_minor = '0;
  logic [19:0] acc_patch = '0;
  logic        mark_pre = 1'b0;
  logic [19:0] kept_major = '0;
  logic [19:0] kept_minor = '0;
  logic [19:0] kept_patch = '0;
  logic        kept_pre = 1'b0;
  logic        kept_ok = 1'b0;

  version_report_t reports_q[$];
  int unsigned     mismatch_count = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     sent_words = 0;
  logic [7:0]      text_q[$];

  function automatic bit is_space(input logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic logic [19:0] sat_accumulate(input logic [19:0] acc,
                                                 input logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - ChZero);
    return (v > SatLimit) ? SatLimit : v[19:0];
  endfunction

  // What may follow a number; dot_next of PH_BAD means no further dot.
  function automatic phase_t after_digits(input logic [7:0] c, input phase_t dot_next);
    if (c == ChDot && dot_next != PH_BAD) return dot_next;
    if (is_space(c)) return PH_TRAIL;
    if (c == ChDash || c == ChPlus) begin
      mark_pre = (c == ChDash);
      return PH_MARK;
    end
    return PH_BAD;
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    case (scan_phase)
      PH_LEAD: begin
        if (is_space(c)) begin
          scan_phase = PH_LEAD;
        end else if (c == ChLowerV || c == ChUpperV) begin
          scan_phase = PH_AFTER_V;
        end else if (is_digit(c)) begin
          acc_major = sat_accumulate(acc_major, c);
          scan_phase = PH_MAJOR;
        end else begin
          scan_phase = PH_BAD;
        end
      end
      PH_AFTER_V: begin
        if (is_digit(c)) begin
          acc_major = sat_accumulate(acc_major, c);
          scan_phase = PH_MAJOR;
        end else begin
          scan_phase = PH_BAD;
        end
      end
      PH_MAJOR: begin
        if (is_digit(c)) acc_major = sat_accumulate(acc_major, c);
        else scan_phase = after_digits(c, PH_DOT1);
      end
      PH_DOT1: begin
        if (is_digit(c)) begin
          acc_minor = sat_accumulate(acc_minor, c);
          scan_phase = PH_MINOR;
        end else begin
          scan_phase = PH_BAD;
        end
      end
      PH_MINOR: begin
        if (is_digit(c)) acc_minor = sat_accumulate(acc_minor, c);
        else scan_phase = after_digits(c, PH_DOT2);
      end
      PH_DOT2: begin
        if (is_digit(c)) begin
          acc_patch = sat_accumulate(acc_patch, c);
          scan_phase = PH_PATCH;
        end else begin
          scan_phase = PH_BAD;
        end
      end
      PH_PATCH: begin
        if (is_digit(c)) acc_patch = sat_accumulate(acc_patch, c);
        else scan_phase = after_digits(c, PH_BAD);
      end
      PH_TRAIL: scan_phase = after_digits(c, PH_BAD);
      PH_MARK, PH_SUFFIX: scan_phase = PH_SUFFIX;
      default: scan_phase = PH_BAD;
    endcase
  endfunction

  // Advances the model by one accepted word and queues the report it causes.
  function automatic void predict_word(input logic [7:0] c, input logic none,
                                       input logic last, input logic second);
    version_report_t r;
    logic            ok;
    if (!none) scan_char(c);
    if (last) begin
      ok = scan_phase inside {PH_MAJOR, PH_MINOR, PH_PATCH, PH_TRAIL, PH_SUFFIX};
      r.major  = ok ? acc_major : '0;
      r.minor  = ok ? acc_minor : '0;
      r.patch  = ok ? acc_patch : '0;
      r.pre    = ok ? mark_pre : 1'b0;
      r.ok     = ok;
      r.second = second;
      r.order  = OrdSame;
      if (!second) begin
        kept_major = r.major;
        kept_minor = r.minor;
        kept_patch = r.patch;
        kept_pre   = r.pre;
        kept_ok    = ok;
      end else if (ok && kept_ok) begin
        if ({kept_major, kept_minor, kept_patch} < {r.major, r.minor, r.patch}) begin
          r.order = OrdOlder;
        end else if ({kept_major, kept_minor, kept_patch} >
                     {r.major, r.minor, r.patch}) begin
          r.order = OrdNewer;
        end else if (kept_pre != r.pre) begin
          // A release is newer than its own pre-release.
          r.order = kept_pre ? OrdOlder : OrdNewer;
        end
      end
      reports_q.insert(reports_q.size(), r);
      scan_phase = PH_LEAD;
      acc_major  = '0;
      acc_minor  = '0;
      acc_patch  = '0;
      mark_pre   = 1'b0;
    end
  endfunction

  // Pop side: check each accepted report and choose pop for the next cycle.
  always @(posedge clk) begin : report_check
    version_report_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (reports_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected report: major %0d minor %0d patch %0d ok %0b",
                     out_major_value, out_minor_value, out_patch_value, out_parsed_ok);
        end else begin
          want = reports_q.pop_front();
          if (out_major_value !== want.major || out_minor_value !== want.minor ||
              out_patch_value !== want.patch || out_is_prerelease !== want.pre ||
              out_parsed_ok !== want.ok || out_result_for_second !== want.second ||
              out_order !== want.order) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("report mismatch: exp %0d.%0d.%0d pre %0b ok %0b b %0b ord %0d,",
                       want.major, want.minor, want.patch, want.pre, want.ok,
                       want.second, want.order);
              $display("  got %0d.%0d.%0d pre %0b ok %0b b %0b ord %0d",
                       out_major_value, out_minor_value, out_patch_value,
                       out_is_prerelease, out_parsed_ok, out_result_for_second,
                       out_order);
            end
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(input logic [7:0] c, input logic none, input logic last,
                           input logic second);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    in_char_code     <= c;
    in_no_char       <= none;
    in_end_of_string <= last;
    in_second_string <= second;
    push             <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_word(c, none, last, second);
  endtask

  // Sends text_q as one string, with the occasional ignored word mixed in when noise_words is set.
  task automatic send_text(input logic second, input bit noise_words);
    int unsigned n;
    bit          end_apart;
    n = text_q.size();
    end_apart = (n == 0) || ($urandom_range(99) < 15);
    for (int unsigned i = 0; i < n; i++) begin
      if (noise_words && $urandom_range(99) < 5)
        send_word(8'($urandom_range(255)), 1'b1, 1'b0, 1'($urandom_range(1)));
      send_word(text_q[i], 1'b0, (i == n - 1) && !end_apart,
                (i == n - 1) ? second : logic'($urandom_range(1)));
      sent_words++;
    end
    if (end_apart) begin
      send_word(8'($urandom_range(255)), 1'b1, 1'b1, second);
      sent_words++;
    end
  endtask

  task automatic wait_for_reports;
    push <= 1'b0;
    while (reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void append_char(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  task automatic put_chars(input string s);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  function automatic int unsigned pick_number();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(3);
    if (r < 75) return $urandom_range(99);
    if (r < 90) return $urandom_range(999999);
    case ($urandom_range(3))
      0: return 999999;
      1: return 1000000;
      2: return 1000001;
      default: return 1000000 + $urandom_range(90000000);
    endcase
  endfunction

  task automatic put_number(input int unsigned n);
    if ($urandom_range(99) < 10) append_char(ChZero);
    put_chars($sformatf("%0d", n));
  endtask

  // Builds a well-formed version string, then maybe breaks it.
  task automatic build_version(input int unsigned maj, input int unsigned mn,
                               input int unsigned pt, input int unsigned parts);
    text_q.delete();
    repeat ($urandom_range(2)) append_char($urandom_range(99) < 50 ? ChSpace :
                                           8'($urandom_range(ChTab, ChCr)));
    case ($urandom_range(3))
      0: append_char(ChLowerV);
      1: append_char(ChUpperV);
      default: ;
    endcase
    put_number(maj);
    if (parts > 1) begin
      append_char(ChDot);
      put_number(mn);
    end
    if (parts > 2) begin
      append_char(ChDot);
      put_number(pt);
    end
    if ($urandom_range(99) < 25) append_char(ChSpace);
    case ($urandom_range(2))
      0: begin
        append_char(ChDash);
        repeat ($urandom_range(1, 3)) append_char(8'($urandom_range(255)));
      end
      1: begin
        append_char(ChPlus);
        repeat ($urandom_range(1, 3)) append_char(8'($urandom_range(255)));
      end
      default: ;
    endcase
    case ($urandom_range(19))
      0, 1: text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      2: while (text_q.size() > $urandom_range(4)) void'(text_q.pop_back());
      3: begin
        text_q.delete();
        repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(255)));
      end
      default: ;
    endcase
  endtask

  task automatic test_directed;
    // A B string before any A is compared with the reset copy, which is invalid.
    text_q = '{8'h31};
    send_text(1'b1, 1'b0);
    // Empty A.
    text_q.delete();
    send_text(1'b0, 1'b0);
    // A marker with nothing after it leaves the string invalid.
    text_q.delete();
    put_chars("1-");
    send_text(1'b0, 1'b0);
    text_q.delete();
    put_chars("v1.2-");
    append_char(8'hFF);
    send_text(1'b0, 1'b0);
    // A release against its own pre-release.
    text_q.delete();
    put_chars("V1.2");
    send_text(1'b1, 1'b0);
    // Saturation behind a tab, with trailing whitespace.
    text_q.delete();
    append_char(ChTab);
    put_chars("9999999 ");
    send_text(1'b0, 1'b0);
    // A word with no character that does not end a string is ignored.
    send_word(8'hFF, 1'b1, 1'b0, 1'b1);
    text_q = '{8'h00};
    send_text(1'b1, 1'b0);
    wait_for_reports();
  endtask

  task automatic test_random_strings(input int unsigned words, input int unsigned s_pct,
                                     input int unsigned r_pct);
    int unsigned stop_at;
    int unsigned a_major, a_minor, a_patch, a_parts;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = sent_words + words;
    while (sent_words < stop_at) begin
      a_major = pick_number();
      a_minor = pick_number();
      a_patch = pick_number();
      a_parts = $urandom_range(1, 3);
      // Now and then a second A replaces the first before any B.
      if ($urandom_range(99) < 10) begin
        build_version(pick_number(), pick_number(), pick_number(), 3);
        send_text(1'b0, 1'b1);
      end
      build_version(a_major, a_minor, a_patch, a_parts);
      send_text(1'b0, 1'b1);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(99) < 50)
          build_version(a_major, a_minor, a_patch,
                        $urandom_range(99) < 70 ? a_parts : $urandom_range(1, 3));
        else
          build_version(pick_number(), pick_number(), pick_number(), $urandom_range(1, 3));
        send_text(1'b1, 1'b1);
      end
      if ($urandom_range(99) < 5) wait_for_reports();
    end
    wait_for_reports();
  endtask

  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 71;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_strings(140, 34, 71);
    test_random_strings(140, 71, 34);
    test_random_strings(140, 0, 0);
    push <= 1'b0;
    while (reports_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && reports_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
